[rtl/core/cce_pkg.sv]
// Shared types, opcodes and sizing constants for the cheat code executor.
`default_nettype none

package cce_pkg;

   // Longest run of byte writes that one repeat line may expand into.
   localparam int unsigned MAX_REPEAT = 64;
   localparam int unsigned CNT_W      = $clog2(MAX_REPEAT + 1);
   localparam int unsigned IDX_W      = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;

   localparam logic [7:0] OP_WRITE_BYTE     = 8'h80;
   localparam logic [7:0] OP_WRITE_BYTE_ALT = 8'hA0;
   localparam logic [7:0] OP_WRITE_HALF     = 8'h81;
   localparam logic [7:0] OP_WRITE_HALF_ALT = 8'hA1;
   localparam logic [7:0] OP_BUTTON_BYTE    = 8'h88;
   localparam logic [7:0] OP_BUTTON_HALF    = 8'h89;
   localparam logic [7:0] OP_EQ_BYTE        = 8'hD0;
   localparam logic [7:0] OP_EQ_HALF        = 8'hD1;
   localparam logic [7:0] OP_NE_BYTE        = 8'hD2;
   localparam logic [7:0] OP_NE_HALF        = 8'hD3;
   localparam logic [7:0] OP_REPEAT         = 8'h50;

   localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;

   localparam logic STATUS_WRITE = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef struct packed {
      logic [7:0]  opcode;
      logic [23:0] target_address;
      logic [15:0] operand_value;
      logic [15:0] memory_contents;
      logic        button_pressed;
      logic        first_line;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] write_address;
      logic [15:0] write_data;
      logic        halfword;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_REPEAT
   } state_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_SINGLE,
      ACT_REPEAT
   } action_type;

   typedef struct packed {
      logic load_line;
      logic exec;
      logic rep_step;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       out_free;
      logic       rep_emit;
      logic       rep_last;
   } sts_type;

endpackage

`default_nettype wire

[rtl/core/cce_ctrl.sv]
// Sequencing state machine of the cheat code executor.
`default_nettype none

module cce_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  cce_pkg::sts_type sts,
   output cce_pkg::cmd_type cmd
);

   cce_pkg::state_type state_ff;
   cce_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cce_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd.load_line = 1'b0;
      cmd.exec      = 1'b0;
      cmd.rep_step  = 1'b0;
      req_stall     = 1'b1;
      case (state_ff)
         cce_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_line = 1'b1;
               state_in      = cce_pkg::ST_DECODE;
            end
         end
         cce_pkg::ST_DECODE: begin
            case (sts.action)
               cce_pkg::ACT_SINGLE: begin
                  // A single result waits for the output register to free up.
                  if (sts.out_free) begin
                     cmd.exec = 1'b1;
                     state_in = cce_pkg::ST_IDLE;
                  end
               end
               cce_pkg::ACT_REPEAT: begin
                  cmd.exec = 1'b1;
                  state_in = cce_pkg::ST_REPEAT;
               end
               default: begin
                  cmd.exec = 1'b1;
                  state_in = cce_pkg::ST_IDLE;
               end
            endcase
         end
         cce_pkg::ST_REPEAT: begin
            // A suppressed write needs no output slot and steps at once.
            if (sts.out_free || !sts.rep_emit) begin
               cmd.rep_step = 1'b1;
               if (sts.rep_last) begin
                  state_in = cce_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = cce_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/core/cce_datapath.sv]
// Line decode, cheat state, repeat stepping and output register.
`default_nettype none

module cce_datapath (
   input  wire              clock,
   input  wire              reset,
   input  cce_pkg::req_type req_payload,
   output cce_pkg::rsp_type rsp_payload,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   input  cce_pkg::cmd_type cmd,
   output cce_pkg::sts_type sts
);

   // Cheat state.
   logic                      run_enable_ff, run_enable_in;
   logic                      repeat_armed_ff, repeat_armed_in;
   logic                      cheat_muted_ff, cheat_muted_in;
   logic [cce_pkg::CNT_W-1:0] repeat_count_ff, repeat_count_in;
   logic [7:0]                addr_step_ff, addr_step_in;
   logic [7:0]                data_step_ff, data_step_in;

   // Current line.
   logic [7:0]  opcode_ff, opcode_in;
   logic [23:0] addr_ff, addr_in;
   logic [15:0] value_ff, value_in;
   logic [15:0] mem_ff, mem_in;
   logic        button_ff, button_in;

   // Repeat run.
   logic [cce_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]               rep_addr_ff, rep_addr_in;
   logic [7:0]                rep_data_ff, rep_data_in;

   // Output register.
   cce_pkg::rsp_type rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Decode results.
   cce_pkg::action_type       action;
   cce_pkg::rsp_type          single_rsp;
   logic                      run_enable_dec;
   logic                      cheat_muted_dec;
   logic                      repeat_armed_dec;
   logic                      arm_load;
   logic [cce_pkg::CNT_W-1:0] sat_count;
   logic                      rep_last;
   logic                      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rep_last = ({1'b0, idx_ff} + cce_pkg::CNT_W'(1)) == repeat_count_ff;

   always_comb begin
      if (addr_ff[15:8] > 8'(cce_pkg::MAX_REPEAT)) begin
         sat_count = cce_pkg::CNT_W'(cce_pkg::MAX_REPEAT);
      end else begin
         sat_count = cce_pkg::CNT_W'(addr_ff[15:8]);
      end
   end

   always_comb begin
      action           = cce_pkg::ACT_NONE;
      run_enable_dec   = run_enable_ff;
      cheat_muted_dec  = cheat_muted_ff;
      repeat_armed_dec = repeat_armed_ff;
      arm_load         = 1'b0;
      single_rsp.status        = cce_pkg::STATUS_WRITE;
      single_rsp.write_address = {8'h00, addr_ff};
      single_rsp.write_data    = {8'h00, value_ff[7:0]};
      single_rsp.halfword      = 1'b0;
      single_rsp.last          = 1'b1;
      if (cheat_muted_ff) begin
         action = cce_pkg::ACT_NONE;
      end else if (repeat_armed_ff) begin
         // The line after a repeat arm is data, whatever its opcode.
         repeat_armed_dec = 1'b0;
         if (repeat_count_ff != '0) begin
            action = cce_pkg::ACT_REPEAT;
         end
      end else begin
         case (opcode_ff)
            cce_pkg::OP_WRITE_BYTE, cce_pkg::OP_WRITE_BYTE_ALT: begin
               run_enable_dec = 1'b1;
               if (run_enable_ff) begin
                  action = cce_pkg::ACT_SINGLE;
               end
            end
            cce_pkg::OP_WRITE_HALF, cce_pkg::OP_WRITE_HALF_ALT: begin
               run_enable_dec        = 1'b1;
               single_rsp.write_data = value_ff;
               single_rsp.halfword   = 1'b1;
               if (run_enable_ff) begin
                  action = cce_pkg::ACT_SINGLE;
               end
            end
            cce_pkg::OP_BUTTON_BYTE: begin
               run_enable_dec = 1'b1;
               if (run_enable_ff && button_ff) begin
                  action = cce_pkg::ACT_SINGLE;
               end
            end
            cce_pkg::OP_BUTTON_HALF: begin
               run_enable_dec        = 1'b1;
               single_rsp.write_data = value_ff;
               single_rsp.halfword   = 1'b1;
               if (run_enable_ff && button_ff) begin
                  action = cce_pkg::ACT_SINGLE;
               end
            end
            cce_pkg::OP_EQ_BYTE: begin
               if (run_enable_ff) begin
                  run_enable_dec = (mem_ff[7:0] == value_ff[7:0]);
               end
            end
            cce_pkg::OP_EQ_HALF: begin
               if (run_enable_ff) begin
                  run_enable_dec = (mem_ff == value_ff);
               end
            end
            cce_pkg::OP_NE_BYTE: begin
               if (run_enable_ff) begin
                  run_enable_dec = (mem_ff[7:0] != value_ff[7:0]);
               end
            end
            cce_pkg::OP_NE_HALF: begin
               if (run_enable_ff) begin
                  run_enable_dec = (mem_ff != value_ff);
               end
            end
            cce_pkg::OP_REPEAT: begin
               repeat_armed_dec = 1'b1;
               arm_load         = 1'b1;
            end
            default: begin
               action                   = cce_pkg::ACT_SINGLE;
               single_rsp.status        = cce_pkg::STATUS_ERROR;
               single_rsp.write_address = '0;
               single_rsp.write_data    = '0;
               cheat_muted_dec          = 1'b1;
               repeat_armed_dec         = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      run_enable_in   = run_enable_ff;
      repeat_armed_in = repeat_armed_ff;
      cheat_muted_in  = cheat_muted_ff;
      repeat_count_in = repeat_count_ff;
      addr_step_in    = addr_step_ff;
      data_step_in    = data_step_ff;
      opcode_in       = opcode_ff;
      addr_in         = addr_ff;
      value_in        = value_ff;
      mem_in          = mem_ff;
      button_in       = button_ff;
      idx_in          = idx_ff;
      rep_addr_in     = rep_addr_ff;
      rep_data_in     = rep_data_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      if (cmd.load_line) begin
         opcode_in = req_payload.opcode;
         addr_in   = req_payload.target_address;
         value_in  = req_payload.operand_value;
         mem_in    = req_payload.memory_contents;
         button_in = req_payload.button_pressed;
         if (req_payload.first_line) begin
            run_enable_in   = 1'b1;
            cheat_muted_in  = 1'b0;
            repeat_armed_in = 1'b0;
         end
      end

      if (cmd.exec) begin
         run_enable_in   = run_enable_dec;
         cheat_muted_in  = cheat_muted_dec;
         repeat_armed_in = repeat_armed_dec;
         if (arm_load) begin
            repeat_count_in = sat_count;
            addr_step_in    = addr_ff[7:0];
            data_step_in    = value_ff[7:0];
         end
         if (action == cce_pkg::ACT_SINGLE) begin
            rsp_in       = single_rsp;
            rsp_valid_in = 1'b1;
         end
         if (action == cce_pkg::ACT_REPEAT) begin
            idx_in      = '0;
            rep_addr_in = {8'h00, addr_ff};
            rep_data_in = value_ff[7:0];
         end
      end

      if (cmd.rep_step) begin
         // A pending false compare swallows only the first write of the run.
         if (run_enable_ff) begin
            rsp_in.status        = cce_pkg::STATUS_WRITE;
            rsp_in.write_address = rep_addr_ff;
            rsp_in.write_data    = {8'h00, rep_data_ff};
            rsp_in.halfword      = 1'b0;
            rsp_in.last          = rep_last;
            rsp_valid_in         = 1'b1;
         end
         run_enable_in = 1'b1;
         idx_in        = idx_ff + cce_pkg::IDX_W'(1);
         rep_addr_in   = rep_addr_ff + {24'h000000, addr_step_ff};
         rep_data_in   = rep_data_ff + data_step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_enable_ff   <= 1'b1;
         repeat_armed_ff <= 1'b0;
         cheat_muted_ff  <= 1'b0;
         repeat_count_ff <= '0;
         addr_step_ff    <= '0;
         data_step_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         run_enable_ff   <= run_enable_in;
         repeat_armed_ff <= repeat_armed_in;
         cheat_muted_ff  <= cheat_muted_in;
         repeat_count_ff <= repeat_count_in;
         addr_step_ff    <= addr_step_in;
         data_step_ff    <= data_step_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opcode_ff   <= opcode_in;
      addr_ff     <= addr_in;
      value_ff    <= value_in;
      mem_ff      <= mem_in;
      button_ff   <= button_in;
      idx_ff      <= idx_in;
      rep_addr_ff <= rep_addr_in;
      rep_data_ff <= rep_data_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_payload  = rsp_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign sts.action   = action;
   assign sts.out_free = out_free;
   assign sts.rep_emit = run_enable_ff;
   assign sts.rep_last = rep_last;

endmodule

`default_nettype wire

[rtl/core/cheat_code_executor.sv]
// Top level of the cheat code executor: controller and datapath.
//
// One decoded cheat line is taken per transfer on the req_ channel and the
// resulting write requests or error leave on the rsp_ channel. The block works
// on one line at a time: a line is taken in the idle state and decoded in the
// decode state, and a plain line may hand its result to the output
// register while it is being drained. The line after a repeat arm steps
// through count byte writes (count up to 64), one write per cycle, as
// the repeat sequencer emits writes one at a time and waits whenever the
// output register is still held by rsp_stall. A result waiting in the output
// register does not keep the next line from being taken.
`default_nettype none

module cheat_code_executor (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  cce_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output cce_pkg::rsp_type rsp_payload
);

   cce_pkg::cmd_type cmd;
   cce_pkg::sts_type sts;

   cce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   cce_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire
